FILE: design/sci_pkg.sv
`default_nettype none
package sci_pkg;

    localparam int CW   = 16;   // coordinate width
    localparam int RADW = 15;   // radius width
    localparam int TOLW = 8;    // tolerance register width
    localparam int QW   = 22;   // projection quotient bits (Q.8)
    localparam int MW   = 56;   // divider remainder width
    localparam int DW   = 25;   // Q.8 difference width
    localparam int SW   = 48;   // square-root radicand width
    localparam int RTW  = 24;   // square-root result bits
    localparam int L2W  = 34;   // squared segment length width

    localparam logic [TOLW-1:0] TOL_RST = 8'd2;
    localparam logic            REG_TOL = 1'b0;   // register index of tolerance

    typedef logic        [MW-1:0] t_rem;
    typedef logic        [QW-1:0] t_quo;
    typedef logic signed [DW-1:0] t_dif;
    typedef logic        [SW-1:0] t_rad;

    // side data carried through the divider
    typedef struct packed {
        logic                  hit_ep;
        logic                  zero;
        logic                  sx;
        logic                  sy;
        logic signed [CW:0]    dx;
        logic signed [CW:0]    dy;
        logic signed [CW:0]    ex;
        logic signed [CW:0]    ey;
        logic        [L2W-1:0] len2;
        logic        [2*RADW-1:0] r2;
    } t_dcar;

    // side data carried through the square-root stages
    typedef struct packed {
        logic hit_ep;
        logic zero;
        logic dist_ok;
    } t_scar;

    typedef struct packed {
        t_rad rad;
        t_rad res;
    } t_sqs;

    // one step of the digit-by-digit integer square root
    function automatic t_sqs sqrt_step(t_sqs s, t_rad bitv);
        t_sqs o;
        t_rad tr;
        tr = s.res + bitv;
        if (s.rad >= tr) begin
            o.rad = s.rad - tr;
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.rad = s.rad;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: design/segment_circle_intersect_top.sv
// Segment / circle intersection test, one pair per beat.
// Input stream (s_axis_*): one beat carries a segment (start, end), a circle
// centre and a radius; coordinates Q12.4, radius unsigned Q11.4. Output
// stream (m_axis_*): one beat per input beat, in order, bit 0 = hit.
// Configuration: APB write of the tolerance register at address 0 (bits 7:0).
// Write it only while the stream is empty.
// Throughput: one beat per cycle unless the output stalls. The path is a
// restoring divider of 22 stages (one quotient bit each) for the projection,
// then 24 square-root stages (one root bit each) for the three distances.
// Every stage carries a valid bit; bubbles flow through.
// Backpressure: when the output register holds a beat that is not taken,
// the whole pipeline freezes and s_axis_tready drops in the same cycle;
// nothing is lost or repeated.
// Reset (synchronous, active low): all valid bits clear, tolerance
// returns to 2.
`default_nettype none
module segment_circle_intersect_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // start_x, start_y, end_x, end_y, centre_x, centre_y, radius[110:96], pad
    input  wire logic [111:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // hit, pad
    output logic [7:0]        m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW   = sci_pkg::CW;
    localparam int RADW = sci_pkg::RADW;
    localparam int QW   = sci_pkg::QW;
    localparam int RTW  = sci_pkg::RTW;
    localparam int L2W  = sci_pkg::L2W;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- configuration ----------------
    logic [sci_pkg::TOLW-1:0] r_tol;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= sci_pkg::TOL_RST;
        end else if (psel && penable && pwrite && paddr[2] == sci_pkg::REG_TOL) begin
            r_tol <= pwdata[sci_pkg::TOLW-1:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[2] == sci_pkg::REG_TOL) begin
            prdata[sci_pkg::TOLW-1:0] = r_tol;
        end
    end

    // ---------------- A: input register ----------------
    logic r_a_v;
    logic signed [CW-1:0] r_a_x1, r_a_y1, r_a_x2, r_a_y2, r_a_cx, r_a_cy;
    logic [RADW-1:0] r_a_r;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en)  r_a_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x1 <= s_axis_tdata[15:0];
            r_a_y1 <= s_axis_tdata[31:16];
            r_a_x2 <= s_axis_tdata[47:32];
            r_a_y2 <= s_axis_tdata[63:48];
            r_a_cx <= s_axis_tdata[79:64];
            r_a_cy <= s_axis_tdata[95:80];
            r_a_r  <= s_axis_tdata[110:96];
        end
    end

    // ---------------- B: differences ----------------
    logic r_b_v;
    logic signed [CW:0] r_b_ex1, r_b_ey1, r_b_ex2, r_b_ey2, r_b_dx, r_b_dy, r_b_wx, r_b_wy;
    logic [RADW-1:0] r_b_r;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else if (en)  r_b_v <= r_a_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ex1 <= {r_a_x1[CW-1], r_a_x1} - {r_a_cx[CW-1], r_a_cx};
            r_b_ey1 <= {r_a_y1[CW-1], r_a_y1} - {r_a_cy[CW-1], r_a_cy};
            r_b_ex2 <= {r_a_x2[CW-1], r_a_x2} - {r_a_cx[CW-1], r_a_cx};
            r_b_ey2 <= {r_a_y2[CW-1], r_a_y2} - {r_a_cy[CW-1], r_a_cy};
            r_b_dx  <= {r_a_x2[CW-1], r_a_x2} - {r_a_x1[CW-1], r_a_x1};
            r_b_dy  <= {r_a_y2[CW-1], r_a_y2} - {r_a_y1[CW-1], r_a_y1};
            r_b_wx  <= {r_a_cx[CW-1], r_a_cx} - {r_a_x1[CW-1], r_a_x1};
            r_b_wy  <= {r_a_cy[CW-1], r_a_cy} - {r_a_y1[CW-1], r_a_y1};
            r_b_r   <= r_a_r;
        end
    end

    // ---------------- C: products ----------------
    logic r_c_v;
    logic signed [2*CW+1:0] r_c_s1x, r_c_s1y, r_c_s2x, r_c_s2y, r_c_sdx, r_c_sdy;
    logic signed [2*CW+1:0] r_c_nx, r_c_ny;
    logic [2*RADW-1:0] r_c_r2;
    logic signed [CW:0] r_c_dx, r_c_dy, r_c_ex, r_c_ey;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else if (en)  r_c_v <= r_b_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_s1x <= r_b_ex1 * r_b_ex1;
            r_c_s1y <= r_b_ey1 * r_b_ey1;
            r_c_s2x <= r_b_ex2 * r_b_ex2;
            r_c_s2y <= r_b_ey2 * r_b_ey2;
            r_c_sdx <= r_b_dx * r_b_dx;
            r_c_sdy <= r_b_dy * r_b_dy;
            r_c_nx  <= r_b_wx * r_b_dx;
            r_c_ny  <= r_b_wy * r_b_dy;
            r_c_r2  <= r_b_r * r_b_r;
            r_c_dx  <= r_b_dx;
            r_c_dy  <= r_b_dy;
            r_c_ex  <= r_b_ex1;
            r_c_ey  <= r_b_ey1;
        end
    end

    // ---------------- D: sums, endpoint test ----------------
    logic r_d_v;
    logic r_d_hit;
    logic [L2W-1:0] r_d_len2;
    logic signed [L2W-1:0] r_d_n;
    logic [2*RADW-1:0] r_d_r2;
    logic signed [CW:0] r_d_dx, r_d_dy, r_d_ex, r_d_ey;
    logic [L2W-1:0] w_e1, w_e2;
    assign w_e1 = $unsigned(r_c_s1x) + $unsigned(r_c_s1y);
    assign w_e2 = $unsigned(r_c_s2x) + $unsigned(r_c_s2y);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else if (en)  r_d_v <= r_c_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_hit  <= (w_e1 <= L2W'(r_c_r2)) || (w_e2 <= L2W'(r_c_r2));
            r_d_len2 <= $unsigned(r_c_sdx) + $unsigned(r_c_sdy);
            r_d_n    <= r_c_nx + r_c_ny;
            r_d_r2   <= r_c_r2;
            r_d_dx   <= r_c_dx;
            r_d_dy   <= r_c_dy;
            r_d_ex   <= r_c_ex;
            r_d_ey   <= r_c_ey;
        end
    end

    // ---------------- E: numerator products ----------------
    logic r_e_v;
    logic signed [L2W+CW:0] r_e_mx, r_e_my;
    sci_pkg::t_dcar r_e_car;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_v <= 1'b0;
        else if (en)  r_e_v <= r_d_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_mx         <= r_d_n * r_d_dx;
            r_e_my         <= r_d_n * r_d_dy;
            r_e_car.hit_ep <= r_d_hit;
            r_e_car.zero   <= (r_d_len2 == '0);
            r_e_car.sx     <= 1'b0;
            r_e_car.sy     <= 1'b0;
            r_e_car.dx     <= r_d_dx;
            r_e_car.dy     <= r_d_dy;
            r_e_car.ex     <= r_d_ex;
            r_e_car.ey     <= r_d_ey;
            r_e_car.len2   <= r_d_len2;
            r_e_car.r2     <= r_d_r2;
        end
    end

    // ---------------- F + divider: rounded projection ----------------
    logic [QW:0] r_dv;
    sci_pkg::t_rem  r_rx [0:QW];
    sci_pkg::t_rem  r_ry [0:QW];
    sci_pkg::t_quo  r_qx [0:QW];
    sci_pkg::t_quo  r_qy [0:QW];
    sci_pkg::t_dcar r_dc [0:QW];
    sci_pkg::t_dcar w_car;
    logic [L2W+CW:0] w_ax, w_ay;
    assign w_ax = r_e_mx[L2W+CW] ? $unsigned(-r_e_mx) : $unsigned(r_e_mx);
    assign w_ay = r_e_my[L2W+CW] ? $unsigned(-r_e_my) : $unsigned(r_e_my);

    // quotient signs ride along with the side data
    always_comb begin
        w_car    = r_e_car;
        w_car.sx = r_e_mx[L2W+CW];
        w_car.sy = r_e_my[L2W+CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else if (en)  r_dv[0] <= r_e_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            // magnitude * 16 plus half the divisor: round half away from zero
            r_rx[0]    <= (sci_pkg::t_rem'(w_ax) << 4) + sci_pkg::t_rem'(r_e_car.len2 >> 1);
            r_ry[0]    <= (sci_pkg::t_rem'(w_ay) << 4) + sci_pkg::t_rem'(r_e_car.len2 >> 1);
            r_qx[0]    <= '0;
            r_qy[0]    <= '0;
            r_dc[0]    <= w_car;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        sci_pkg::t_rem w_den;
        logic w_gex, w_gey;
        assign w_den = sci_pkg::t_rem'(r_dc[j-1].len2) << (QW - j);
        assign w_gex = r_rx[j-1] >= w_den;
        assign w_gey = r_ry[j-1] >= w_den;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[j] <= 1'b0;
            else if (en)  r_dv[j] <= r_dv[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rx[j] <= w_gex ? r_rx[j-1] - w_den : r_rx[j-1];
                r_ry[j] <= w_gey ? r_ry[j-1] - w_den : r_ry[j-1];
                r_qx[j] <= r_qx[j-1] | (sci_pkg::t_quo'(w_gex) << (QW - j));
                r_qy[j] <= r_qy[j-1] | (sci_pkg::t_quo'(w_gey) << (QW - j));
                r_dc[j] <= r_dc[j-1];
            end
        end
    end

    // ---------------- H: Q.8 offsets ----------------
    // d1 = P - start, d2 = P - end, o = P - centre, all relative to start
    logic r_h_v;
    sci_pkg::t_dif r_h_d1x, r_h_d1y, r_h_d2x, r_h_d2y, r_h_ox, r_h_oy;
    sci_pkg::t_dcar r_h_car;
    logic signed [QW:0] w_qsx, w_qsy;
    assign w_qsx = r_dc[QW].sx ? -$signed({1'b0, r_qx[QW]}) : $signed({1'b0, r_qx[QW]});
    assign w_qsy = r_dc[QW].sy ? -$signed({1'b0, r_qy[QW]}) : $signed({1'b0, r_qy[QW]});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_v <= 1'b0;
        else if (en)  r_h_v <= r_dv[QW];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_d1x <= sci_pkg::t_dif'(w_qsx);
            r_h_d1y <= sci_pkg::t_dif'(w_qsy);
            r_h_d2x <= sci_pkg::t_dif'(w_qsx) - (sci_pkg::t_dif'(r_dc[QW].dx) <<< 4);
            r_h_d2y <= sci_pkg::t_dif'(w_qsy) - (sci_pkg::t_dif'(r_dc[QW].dy) <<< 4);
            r_h_ox  <= sci_pkg::t_dif'(w_qsx) + (sci_pkg::t_dif'(r_dc[QW].ex) <<< 4);
            r_h_oy  <= sci_pkg::t_dif'(w_qsy) + (sci_pkg::t_dif'(r_dc[QW].ey) <<< 4);
            r_h_car <= r_dc[QW];
        end
    end

    // ---------------- I: squares ----------------
    localparam int DW = sci_pkg::DW;
    logic r_i_v;
    logic signed [2*DW-1:0] r_i_a1x, r_i_a1y, r_i_a2x, r_i_a2y, r_i_aox, r_i_aoy;
    sci_pkg::t_dcar r_i_car;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_i_v <= 1'b0;
        else if (en)  r_i_v <= r_h_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_a1x <= r_h_d1x * r_h_d1x;
            r_i_a1y <= r_h_d1y * r_h_d1y;
            r_i_a2x <= r_h_d2x * r_h_d2x;
            r_i_a2y <= r_h_d2y * r_h_d2y;
            r_i_aox <= r_h_ox * r_h_ox;
            r_i_aoy <= r_h_oy * r_h_oy;
            r_i_car <= r_h_car;
        end
    end

    // ---------------- J + square roots ----------------
    logic [RTW:0] r_sv;
    sci_pkg::t_sqs  r_s1 [0:RTW];
    sci_pkg::t_sqs  r_s2 [0:RTW];
    sci_pkg::t_sqs  r_s3 [0:RTW];
    sci_pkg::t_scar r_sc [0:RTW];
    logic [2*DW:0] w_dist;
    assign w_dist = $unsigned(r_i_aox) + $unsigned(r_i_aoy);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else if (en)  r_sv[0] <= r_i_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0].rad <= sci_pkg::t_rad'($unsigned(r_i_a1x) + $unsigned(r_i_a1y));
            r_s2[0].rad <= sci_pkg::t_rad'($unsigned(r_i_a2x) + $unsigned(r_i_a2y));
            r_s3[0].rad <= sci_pkg::t_rad'(r_i_car.len2) << 8;
            r_s1[0].res <= '0;
            r_s2[0].res <= '0;
            r_s3[0].res <= '0;
            r_sc[0].hit_ep  <= r_i_car.hit_ep;
            r_sc[0].zero    <= r_i_car.zero;
            // (radius*16)^2 = radius^2 << 8
            r_sc[0].dist_ok <= w_dist <= ((2*DW+1)'(r_i_car.r2) << 8);
        end
    end

    for (genvar k = 1; k <= RTW; k++) begin : g_sqrt
        localparam sci_pkg::t_rad BITV = sci_pkg::t_rad'(1) << (2 * (RTW - k));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k] <= 1'b0;
            else if (en)  r_sv[k] <= r_sv[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s1[k] <= sci_pkg::sqrt_step(r_s1[k-1], BITV);
                r_s2[k] <= sci_pkg::sqrt_step(r_s2[k-1], BITV);
                r_s3[k] <= sci_pkg::sqrt_step(r_s3[k-1], BITV);
                r_sc[k] <= r_sc[k-1];
            end
        end
    end

    // ---------------- output: on-segment window and final flag ----------------
    logic [RTW+1:0] w_sum, w_len, w_t;
    logic w_onseg, w_hit;
    assign w_sum   = (RTW+2)'(r_s1[RTW].res[RTW-1:0]) + (RTW+2)'(r_s2[RTW].res[RTW-1:0]);
    assign w_len   = (RTW+2)'(r_s3[RTW].res[RTW-1:0]);
    assign w_t     = (RTW+2)'({r_tol, 4'b0000});
    assign w_onseg = (w_sum + w_t >= w_len) && (w_sum <= w_len + w_t);
    assign w_hit   = r_sc[RTW].hit_ep
                   || (!r_sc[RTW].zero && w_onseg && r_sc[RTW].dist_ok);

    logic r_out_v, r_out_hit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (en)  r_out_v <= r_sv[RTW];
    end
    always_ff @(posedge i_clk) begin
        if (en) r_out_hit <= w_hit;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {7'b0000000, r_out_hit};

endmodule
`default_nettype wire

FILE: design/sci_chk.sv
`default_nettype none
module sci_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [7:0]   m_axis_tdata,
    input wire logic         pready
);

    // a held result must stay offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // a stalled output freezes the pipe, so input must not be taken
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // reset empties the pipe
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0000000)
        else $error("output padding not zero");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind segment_circle_intersect_top sci_chk u_sci_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
`default_nettype wire
